/* sv/rc5ir_pkg.sv */
// Shared types and constants for the RC5 infrared edge decoder.
`default_nettype none

package rc5ir_pkg;

  typedef enum logic {
    OpEdge = 1'b0,
    OpAck  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CfgMinHalfBit = 2'd0,
    CfgMaxHalfBit = 2'd1,
    CfgMaxBit     = 2'd2
  } cfg_idx_e;

  localparam int unsigned TimeW  = 16;
  localparam int unsigned QueueDepth = 2;

  localparam logic [TimeW-1:0] MinHalfBitRst = 16'd640;
  localparam logic [TimeW-1:0] MaxHalfBitRst = 16'd1140;
  localparam logic [TimeW-1:0] MaxBitRst     = 16'd2000;

  // frame is complete once the 13th bit is in
  localparam logic [3:0] LastBitIdx = 4'd12;

  typedef struct packed {
    logic [TimeW-1:0] half_min;
    logic [TimeW-1:0] half_max;
    logic [TimeW-1:0] max_bit;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [TimeW-1:0] capture_time;
  } item_t;

  typedef struct packed {
    logic       code_pending;
    logic [4:0] rc_address;
    logic [5:0] rc_command;
    logic       toggle;
    logic       edge_select;
  } result_t;

endpackage

`default_nettype wire

/* sv/rc5ir_queue.sv */
// Small two-entry FIFO used between the decoder stages.
`default_nettype none

module rc5ir_queue #(
  parameter int unsigned Width = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);
  import rc5ir_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  logic [Width-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? PtrW'(wr_q + 1'b1) : wr_q;
    rd_d  = do_pop  ? PtrW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = (PtrW+1)'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = (PtrW+1)'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* sv/rc5ir_front.sv */
// Front end: takes input transfers, classifies the operation and queues them.
`default_nettype none

module rc5ir_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              operation_i,
  input  wire logic [15:0]       capture_time_i,
  output rc5ir_pkg::item_t       item_o,
  output logic                   item_valid_o,
  input  wire logic              item_ready_i
);
  import rc5ir_pkg::*;

  item_t item_in;
  logic  q_empty;

  always_comb begin
    item_in.op           = operation_i ? OpAck : OpEdge;
    // timestamp is meaningless for an acknowledge
    item_in.capture_time = operation_i ? '0 : capture_time_i;
  end

  rc5ir_queue #(
    .Width($bits(item_t))
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (item_in),
    .full_o (full),
    .pop_i  (item_ready_i),
    .data_o (item_o),
    .empty_o(q_empty)
  );

  assign item_valid_o = !q_empty;

endmodule

`default_nettype wire

/* sv/rc5ir_back.sv */
// Back end: pulse timing, Manchester bit recovery, code latch and result queue.
`default_nettype none

module rc5ir_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rc5ir_pkg::cfg_t   cfg_i,
  input  wire rc5ir_pkg::item_t  item_i,
  input  wire logic              item_valid_i,
  output logic                   item_ready_o,
  input  wire logic              pop,
  output logic                   empty,
  output rc5ir_pkg::result_t     result_o
);
  import rc5ir_pkg::*;

  logic [TimeW-1:0] last_q, last_d;
  logic             pol_q, pol_d;
  logic [5:0]       hbc_q, hbc_d;
  logic [15:0]      shift_q, shift_d;
  logic [3:0]       bits_q, bits_d;
  logic             pend_q, pend_d;
  logic [11:0]      code_q, code_d;

  logic             take, out_full;
  logic [TimeW-1:0] pw;
  logic [5:0]       hbc0, hbc1;
  logic             pol_t, restart;
  result_t          res;

  assign item_ready_o = !out_full;
  assign take         = item_valid_i && !out_full;
  assign pw           = TimeW'(item_i.capture_time - last_q);

  always_comb begin
    last_d  = last_q;
    pol_d   = pol_q;
    hbc_d   = hbc_q;
    shift_d = shift_q;
    bits_d  = bits_q;
    pend_d  = pend_q;
    code_d  = code_q;
    restart = 1'b0;
    pol_t   = ~pol_q;
    hbc0    = (pw > cfg_i.max_bit) ? '0 : hbc_q;
    hbc1    = (pw > cfg_i.half_max) ? 6'(hbc0 + 1'b1) : hbc0;
    unique case (item_i.op)
      OpAck: begin
        pend_d = 1'b0;
      end
      OpEdge: begin
        last_d = item_i.capture_time;
        if (hbc0 == '0) begin
          // frame start
          shift_d = '0;
          bits_d  = '0;
          pol_d   = 1'b1;
          hbc_d   = 6'd1;
        end else if (pw < cfg_i.half_min) begin
          restart = 1'b1;
        end else begin
          if (hbc1 > 6'd1 && !hbc1[0]) begin
            shift_d = {shift_q[14:0], pol_t};
            bits_d  = 4'(bits_q + 1'b1);
            if (bits_d > LastBitIdx) begin
              // a code still waiting keeps its fields
              if (!pend_q) begin
                code_d = shift_d[11:0];
              end
              pend_d  = 1'b1;
              restart = 1'b1;
            end
          end
          hbc_d = 6'(hbc1 + 1'b1);
          pol_d = pol_t;
        end
        if (restart) begin
          hbc_d = '0;
          pol_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      pol_q   <= 1'b0;
      hbc_q   <= '0;
      shift_q <= '0;
      bits_q  <= '0;
      pend_q  <= 1'b0;
      code_q  <= '0;
    end else if (take) begin
      last_q  <= last_d;
      pol_q   <= pol_d;
      hbc_q   <= hbc_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
      pend_q  <= pend_d;
      code_q  <= code_d;
    end
  end

  always_comb begin
    res.code_pending = pend_d;
    res.rc_address   = code_d[10:6];
    res.rc_command   = code_d[5:0];
    res.toggle       = code_d[11];
    res.edge_select  = pol_d;
  end

  rc5ir_queue #(
    .Width($bits(result_t))
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (take),
    .data_i (res),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (result_o),
    .empty_o(empty)
  );

endmodule

`default_nettype wire

/* sv/rc5_ir_edge_decoder.sv */
// RC5 infrared decoder working on edge timestamps: configuration registers and stage wiring.
//
// Input side behaves as a queue: an item (operation, capture_time) transfers on a
// rising edge with push high and full low. operation 0 is a captured edge with its
// 16-bit timer value, operation 1 acknowledges and clears the pending code.
// Result side: while empty is low the oldest result sits on the result ports and
// transfers on a rising edge with pop high. Every item gives exactly one result
// (pending flag, latched address/command/toggle, next expected edge polarity).
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i 0 shortest half bit,
// 1 longest half bit, 2 max_bit; index 3 is ignored. Write only while idle.
// Items are registered in the input queue, their results in the result queue.
// Throughput: one item per cycle while the result queue is not full; the back stage does
// the whole pulse update combinationally, so the rate is set only by the two-entry queues.
// A stalled receiver fills the result queue, then the input queue, then full rises.
// Reset clears decoder state and restores the default thresholds.
`default_nettype none

module rc5_ir_edge_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic        operation_i,
  input  wire logic [15:0] capture_time_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             code_pending_o,
  output logic [4:0]       rc_address_o,
  output logic [5:0]       rc_command_o,
  output logic             toggle_o,
  output logic             edge_select_o
);
  import rc5ir_pkg::*;

  cfg_t    cfg_q, cfg_d;
  item_t   item;
  logic    item_valid, item_ready;
  result_t res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMinHalfBit: cfg_d.half_min = cfg_data_i;
        CfgMaxHalfBit: cfg_d.half_max = cfg_data_i;
        CfgMaxBit:     cfg_d.max_bit  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_min <= MinHalfBitRst;
      cfg_q.half_max <= MaxHalfBitRst;
      cfg_q.max_bit  <= MaxBitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rc5ir_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .operation_i   (operation_i),
    .capture_time_i(capture_time_i),
    .item_o        (item),
    .item_valid_o  (item_valid),
    .item_ready_i  (item_ready)
  );

  rc5ir_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (item),
    .item_valid_i(item_valid),
    .item_ready_o(item_ready),
    .pop         (pop),
    .empty       (empty),
    .result_o    (res)
  );

  assign code_pending_o = res.code_pending;
  assign rc_address_o   = res.rc_address;
  assign rc_command_o   = res.rc_command;
  assign toggle_o       = res.toggle;
  assign edge_select_o  = res.edge_select;

endmodule

`default_nettype wire
